/* hdl/osm_pkg.sv */
// ----------------------------------------------------------------------------
// osm_pkg
// Shared capacity, widths, operation codes and status codes for the sorted multiset.
// ----------------------------------------------------------------------------
`default_nettype none

package osm_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int KIND_W   = 3;
  localparam int STATUS_W = 2;
  localparam int OUT_W    = 40;

  localparam logic [KIND_W-1:0] OP_INSERT = 3'd0;
  localparam logic [KIND_W-1:0] OP_ERASE  = 3'd1;
  localparam logic [KIND_W-1:0] OP_RANK   = 3'd2;
  localparam logic [KIND_W-1:0] OP_KTH    = 3'd3;
  localparam logic [KIND_W-1:0] OP_PRED   = 3'd4;
  localparam logic [KIND_W-1:0] OP_SUCC   = 3'd5;

  localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY  = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_ABSENT = 2'd3;

endpackage

`default_nettype wire

/* hdl/order_statistic_multiset_core.sv */
// ----------------------------------------------------------------------------
// order_statistic_multiset_core
// Bounded sorted multiset of signed 32-bit values with rank and order queries.
// ----------------------------------------------------------------------------
// Entries sit in ascending order in a single-port-read RAM. Rank, erase,
// insert, predecessor and successor first scan all n stored entries through
// one signed comparator, one entry a cycle; kth skips the scan.
// Insert and erase then shift the entries above the slot, each moved entry
// read in S_MVRD and written in S_MVWR; the RAM offers one read and one
// write a cycle, with registered read data. Kth, predecessor and successor
// read their answer in S_FETCH and S_FWAIT; S_DONE loads the result. The
// input is not ready while an item is in progress; a waiting result does not
// block accepting the next item, which holds in S_DONE until it is taken.
`default_nettype none

module order_statistic_multiset_core #(
  parameter int CAPACITY = osm_pkg::CAPACITY
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  input  wire logic [osm_pkg::KIND_W-1:0]   s_tuser,  // kind
  input  wire logic [osm_pkg::DATA_W-1:0]   s_tdata,  // operand
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  output logic      [osm_pkg::OUT_W-1:0]    m_tdata   // answer, status, zero pad
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SCAN  = 8'b0000_0010,
    S_MVRD  = 8'b0000_0100,
    S_MVWR  = 8'b0000_1000,
    S_PUT   = 8'b0001_0000,
    S_FETCH = 8'b0010_0000,
    S_FWAIT = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t                         state;
  logic [osm_pkg::KIND_W-1:0]     kind;
  logic [osm_pkg::DATA_W-1:0]     operand;
  logic [CW-1:0]                  count;
  logic [CW-1:0]                  idx;
  logic                           pend;
  logic [CW-1:0]                  lt;
  logic [CW-1:0]                  le;
  logic [CW-1:0]                  ptr;
  logic [AW-1:0]                  pos;
  logic [osm_pkg::DATA_W-1:0]     answer;
  logic [osm_pkg::STATUS_W-1:0]   status;
  logic                           out_valid;
  logic [osm_pkg::DATA_W-1:0]     out_answer;
  logic [osm_pkg::STATUS_W-1:0]   out_status;
  logic                           load;

  logic                           we;
  logic [AW-1:0]                  waddr;
  logic [osm_pkg::DATA_W-1:0]     wdata;
  logic [AW-1:0]                  raddr;
  logic [osm_pkg::DATA_W-1:0]     rdata;
  logic                           less;
  logic                           equal;
  logic [CW-1:0]                  src;
  logic [CW-1:0]                  kth_idx;

  osm_ram #(
    .WIDTH(osm_pkg::DATA_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // shared comparator
  assign less  = $signed(rdata) < $signed(operand);
  assign equal = rdata == operand;

  assign src = (kind == osm_pkg::OP_INSERT) ? ptr - CW'(1) : ptr + CW'(1);

  always_comb begin
    if (s_tdata[osm_pkg::DATA_W-1] || s_tdata == '0) begin
      kth_idx = '0;
    end else if (s_tdata >= osm_pkg::DATA_W'(count)) begin
      kth_idx = count - CW'(1);
    end else begin
      kth_idx = s_tdata[CW-1:0] - CW'(1);
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = ptr[AW-1:0];
    wdata = rdata;
    raddr = idx[AW-1:0];
    unique case (state)
      S_MVRD:  raddr = src[AW-1:0];
      S_MVWR:  we = 1'b1;
      S_PUT: begin
        we    = 1'b1;
        waddr = pos;
        wdata = operand;
      end
      S_FETCH: raddr = ptr[AW-1:0];
      default: ;
    endcase
  end

  assign s_tready = (state == S_IDLE) && !rst;
  assign m_tvalid = out_valid;
  assign m_tdata  = {(osm_pkg::OUT_W - osm_pkg::DATA_W - osm_pkg::STATUS_W)'(0),
                     out_status, out_answer};

  assign load = (state == S_DONE) && (!out_valid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            kind    <= s_tuser;
            operand <= s_tdata;
            answer  <= '0;
            status  <= osm_pkg::STAT_OK;
            idx     <= '0;
            pend    <= 1'b0;
            lt      <= '0;
            le      <= '0;
            case (s_tuser)
              osm_pkg::OP_INSERT: begin
                if (count == CW'(CAPACITY)) begin
                  status <= osm_pkg::STAT_FULL;
                  state  <= S_DONE;
                end else begin
                  state <= S_SCAN;
                end
              end
              osm_pkg::OP_ERASE, osm_pkg::OP_RANK: state <= S_SCAN;
              osm_pkg::OP_KTH: begin
                if (count == '0) begin
                  status <= osm_pkg::STAT_EMPTY;
                  state  <= S_DONE;
                end else begin
                  ptr   <= kth_idx;
                  state <= S_FETCH;
                end
              end
              osm_pkg::OP_PRED, osm_pkg::OP_SUCC: begin
                if (count == '0) begin
                  status <= osm_pkg::STAT_EMPTY;
                  state  <= S_DONE;
                end else begin
                  state <= S_SCAN;
                end
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_SCAN: begin
          if (pend) begin
            if (less) begin
              lt <= lt + CW'(1);
            end
            if (less || equal) begin
              le <= le + CW'(1);
            end
          end
          if (idx != count) begin
            idx  <= idx + CW'(1);
            pend <= 1'b1;
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              case (kind)
                osm_pkg::OP_INSERT: begin
                  pos   <= le[AW-1:0];
                  ptr   <= count;
                  state <= (le == count) ? S_PUT : S_MVRD;
                end
                osm_pkg::OP_ERASE: begin
                  if (le == lt) begin
                    status <= osm_pkg::STAT_ABSENT;
                    state  <= S_DONE;
                  end else if (lt + CW'(1) == count) begin
                    count <= count - CW'(1);
                    state <= S_DONE;
                  end else begin
                    ptr   <= lt;
                    state <= S_MVRD;
                  end
                end
                osm_pkg::OP_RANK: begin
                  answer <= osm_pkg::DATA_W'(lt) + osm_pkg::DATA_W'(1);
                  if (count == '0) begin
                    status <= osm_pkg::STAT_EMPTY;
                  end
                  state <= S_DONE;
                end
                osm_pkg::OP_PRED: begin
                  ptr   <= (lt == '0) ? '0 : lt - CW'(1);
                  state <= S_FETCH;
                end
                default: begin
                  ptr   <= (le >= count) ? count - CW'(1) : le;
                  state <= S_FETCH;
                end
              endcase
            end
          end
        end
        S_MVRD: state <= S_MVWR;
        S_MVWR: begin
          if (kind == osm_pkg::OP_INSERT) begin
            ptr   <= ptr - CW'(1);
            state <= (ptr - CW'(1) == CW'(pos)) ? S_PUT : S_MVRD;
          end else begin
            ptr <= ptr + CW'(1);
            if (ptr + CW'(2) == count) begin
              count <= count - CW'(1);
              state <= S_DONE;
            end else begin
              state <= S_MVRD;
            end
          end
        end
        S_PUT: begin
          count <= count + CW'(1);
          state <= S_DONE;
        end
        S_FETCH: state <= S_FWAIT;
        S_FWAIT: begin
          answer <= rdata;
          state  <= S_DONE;
        end
        S_DONE: begin
          if (load) begin
            out_answer <= answer;
            out_status <= status;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* hdl/osm_ram.sv */
// ----------------------------------------------------------------------------
// osm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module osm_ram #(
  parameter int WIDTH = osm_pkg::DATA_W,
  parameter int DEPTH = osm_pkg::CAPACITY
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hdl/osm_checker.sv */
// ----------------------------------------------------------------------------
// osm_checker
// Port-level checks on the sorted multiset core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module osm_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       s_tvalid,
  input wire logic                       s_tready,
  input wire logic                       m_tvalid,
  input wire logic                       m_tready,
  input wire logic [osm_pkg::OUT_W-1:0]  m_tdata
);

  // reset empties the result register
  a_reset_clears: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // one item at a time: input closes after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input ready straight after accept");

  // pad bits stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[osm_pkg::OUT_W-1:osm_pkg::DATA_W+osm_pkg::STATUS_W] == '0))
    else $error("result pad bits set");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

endmodule

bind order_statistic_multiset_core osm_checker u_osm_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);

`default_nettype wire
